// ----- rtl/core/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the bilinear pixel sampler.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 8;
    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 18;
    localparam int SIZE_BITS  = 9;
    localparam int COL_BITS   = 8;
    localparam int ROW_BITS   = 8;
    localparam int OUT_BITS   = 16;

    // Four banks split by row and column parity.
    localparam int NUM_BANKS      = 4;
    localparam int BANK_COL_BITS  = COL_BITS - 1;
    localparam int BANK_ROW_BITS  = ROW_BITS - 1;
    localparam int BANK_ADDR_BITS = BANK_COL_BITS + BANK_ROW_BITS;
    localparam int BANK_DEPTH     = MAX_WIDTH * MAX_HEIGHT / NUM_BANKS;

    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int COLSUM_BITS = PIXEL_BITS + FRAC_BITS;
    localparam int ACC_BITS    = PIXEL_BITS + 2 * FRAC_BITS;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << FRAC_BITS);
    localparam logic [SIZE_BITS-1:0]   SIZE_RESET = SIZE_BITS'(256);
    localparam logic [SIZE_BITS-1:0]   SIZE_MAX_W = SIZE_BITS'(MAX_WIDTH);
    localparam logic [SIZE_BITS-1:0]   SIZE_MAX_H = SIZE_BITS'(MAX_HEIGHT);

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Input command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Per-sample control that travels with the memory read.
    typedef struct packed {
        logic                 valid;
        logic                 in_image;
        logic [FRAC_BITS-1:0] dx;
        logic [FRAC_BITS-1:0] dy;
        logic                 x_odd;
        logic                 y_odd;
    } sample_ctl_t;

endpackage

// ----- rtl/core/bps_ram.sv -----
// ----------------------------------------------------------------------------
// bps_ram
// Generic single-port RAM with one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bps_front.sv -----
// ----------------------------------------------------------------------------
// bps_front
// Configuration registers, coordinate decode and bank address generation.
// ----------------------------------------------------------------------------
module bps_front
    import bps_pkg::*;
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_write,
    input  logic                                      cfg_index,
    input  logic [SIZE_BITS-1:0]                      cfg_data,
    input  logic                                      accept,
    input  logic                                      cmd,
    input  logic [COL_BITS-1:0]                       write_col,
    input  logic [ROW_BITS-1:0]                       write_row,
    input  logic [PIXEL_BITS-1:0]                     write_value,
    input  logic signed [COORD_BITS-1:0]              sample_x,
    input  logic signed [COORD_BITS-1:0]              sample_y,
    output logic [NUM_BANKS-1:0]                      bank_we,
    output logic [NUM_BANKS-1:0][BANK_ADDR_BITS-1:0]  bank_addr,
    output logic [PIXEL_BITS-1:0]                     bank_wdata,
    output sample_ctl_t                               ctl
);

    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;
    logic [SIZE_BITS-1:0] cfg_clamped_w;
    logic [SIZE_BITS-1:0] cfg_clamped_h;

    logic                 far_out;
    logic [16:0]          x_clamp;
    logic [16:0]          y_clamp;
    logic [SIZE_BITS-1:0] x_cell;
    logic [SIZE_BITS-1:0] y_cell;
    logic                 beyond;
    logic                 last_cell;
    logic                 is_sample;
    logic [BANK_COL_BITS-1:0] col_even;
    logic [BANK_COL_BITS-1:0] col_odd;
    logic [BANK_ROW_BITS-1:0] row_even;
    logic [BANK_ROW_BITS-1:0] row_odd;
    logic [1:0]           wr_bank;

    sample_ctl_t ctl_reg;
    sample_ctl_t ctl_next;

    // Zero acts as one, anything above the store size saturates.
    always_comb
    begin
        cfg_clamped_w = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped_w = SIZE_BITS'(1);
        end
        else if (cfg_data > SIZE_MAX_W)
        begin
            cfg_clamped_w = SIZE_MAX_W;
        end
        cfg_clamped_h = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped_h = SIZE_BITS'(1);
        end
        else if (cfg_data > SIZE_MAX_H)
        begin
            cfg_clamped_h = SIZE_MAX_H;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_clamped_w;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_clamped_h;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Coordinate decode: range check, clamp of small negatives, cell split.
    always_comb
    begin
        far_out = (sample_x < -COORD_BITS'(signed'(128)))
               || (sample_y < -COORD_BITS'(signed'(128)))
               || ($signed({sample_x[COORD_BITS-1], sample_x})
                   > $signed({2'b00, width_reg, 8'h00}))
               || ($signed({sample_y[COORD_BITS-1], sample_y})
                   > $signed({2'b00, height_reg, 8'h00}));

        x_clamp = sample_x[COORD_BITS-1] ? '0 : sample_x[16:0];
        y_clamp = sample_y[COORD_BITS-1] ? '0 : sample_y[16:0];
        x_cell  = x_clamp[16:FRAC_BITS];
        y_cell  = y_clamp[16:FRAC_BITS];

        beyond    = (x_cell >= width_reg) || (y_cell >= height_reg);
        last_cell = (x_cell + SIZE_BITS'(1) == width_reg)
                 || (y_cell + SIZE_BITS'(1) == height_reg);

        is_sample = accept && (cmd == CMD_SAMPLE);

        ctl_next.valid    = is_sample;
        ctl_next.in_image = !far_out && !beyond;
        // Zero weights on the last column or row return the raw pixel.
        ctl_next.dx       = last_cell ? '0 : x_clamp[FRAC_BITS-1:0];
        ctl_next.dy       = last_cell ? '0 : y_clamp[FRAC_BITS-1:0];
        ctl_next.x_odd    = x_cell[0];
        ctl_next.y_odd    = y_cell[0];
    end

    // Even banks hold the neighbor one step ahead when the cell is odd.
    always_comb
    begin
        col_odd  = x_cell[COL_BITS-1:1];
        col_even = x_cell[COL_BITS-1:1] + BANK_COL_BITS'(x_cell[0]);
        row_odd  = y_cell[ROW_BITS-1:1];
        row_even = y_cell[ROW_BITS-1:1] + BANK_ROW_BITS'(y_cell[0]);
        wr_bank  = {write_row[0], write_col[0]};

        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (accept && (cmd == CMD_WRITE))
            begin
                bank_addr[b] = {write_row[ROW_BITS-1:1], write_col[COL_BITS-1:1]};
                bank_we[b]   = (wr_bank == 2'(b));
            end
            else
            begin
                bank_addr[b] = {(b[1] ? row_odd : row_even),
                                (b[0] ? col_odd : col_even)};
                bank_we[b]   = 1'b0;
            end
        end
    end

    assign bank_wdata = write_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign ctl = ctl_reg;

endmodule

// ----- rtl/core/bps_interp.sv -----
// ----------------------------------------------------------------------------
// bps_interp
// Three-stage weighting pipeline: column blend, row blend, sum and output.
// ----------------------------------------------------------------------------
module bps_interp
    import bps_pkg::*;
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sample_ctl_t                           ctl,
    input  logic [NUM_BANKS-1:0][PIXEL_BITS-1:0]  bank_rdata,
    output logic                                  done,
    output logic [OUT_BITS-1:0]                   interp_value,
    output logic                                  inside_res
);

    logic [PIXEL_BITS-1:0]  p00;
    logic [PIXEL_BITS-1:0]  p01;
    logic [PIXEL_BITS-1:0]  p10;
    logic [PIXEL_BITS-1:0]  p11;
    logic [WEIGHT_BITS-1:0] dy1;
    logic [WEIGHT_BITS-1:0] dx1;
    logic [COLSUM_BITS:0]   col_a_sum;
    logic [COLSUM_BITS:0]   col_b_sum;
    logic [ACC_BITS-1:0]    acc_sum;

    logic [COLSUM_BITS-1:0] col_a_reg;
    logic [COLSUM_BITS-1:0] col_b_reg;
    logic [FRAC_BITS-1:0]   dx_reg;
    logic                   inside_s2_reg;
    logic                   valid_s2_reg;
    logic [ACC_BITS-1:0]    term0_reg;
    logic [ACC_BITS-1:0]    term1_reg;
    logic                   inside_s3_reg;
    logic                   valid_s3_reg;
    logic                   done_reg;
    logic [OUT_BITS-1:0]    value_reg;
    logic                   inside_reg;

    // Route banks to neighbors by the parity of the cell. Drop a neighbor
    // whose weight is zero, so a raw pixel never depends on unwritten ones.
    always_comb
    begin
        p00 = bank_rdata[{ctl.y_odd,  ctl.x_odd}];
        p10 = (ctl.dx == '0) ? '0 : bank_rdata[{ctl.y_odd, !ctl.x_odd}];
        p01 = (ctl.dy == '0) ? '0 : bank_rdata[{!ctl.y_odd,  ctl.x_odd}];
        p11 = (ctl.dx == '0 || ctl.dy == '0) ? '0
                                             : bank_rdata[{!ctl.y_odd, !ctl.x_odd}];
        dy1 = WEIGHT_ONE - WEIGHT_BITS'(ctl.dy);
        col_a_sum = (COLSUM_BITS+1)'(dy1) * (COLSUM_BITS+1)'(p00)
                  + (COLSUM_BITS+1)'(ctl.dy) * (COLSUM_BITS+1)'(p01);
        col_b_sum = (COLSUM_BITS+1)'(dy1) * (COLSUM_BITS+1)'(p10)
                  + (COLSUM_BITS+1)'(ctl.dy) * (COLSUM_BITS+1)'(p11);
        dx1 = WEIGHT_ONE - WEIGHT_BITS'(dx_reg);
        acc_sum = term0_reg + term1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_s2_reg <= ctl.valid;
            valid_s3_reg <= valid_s2_reg;
            done_reg     <= valid_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Column blend across the two rows.
        col_a_reg     <= col_a_sum[COLSUM_BITS-1:0];
        col_b_reg     <= col_b_sum[COLSUM_BITS-1:0];
        dx_reg        <= ctl.dx;
        inside_s2_reg <= ctl.in_image;
        // Row blend across the two columns.
        term0_reg     <= ACC_BITS'(dx1) * ACC_BITS'(col_a_reg);
        term1_reg     <= ACC_BITS'(dx_reg) * ACC_BITS'(col_b_reg);
        inside_s3_reg <= inside_s2_reg;
        // Drop the extra fraction bits, zero the value when outside.
        value_reg     <= inside_s3_reg ? acc_sum[ACC_BITS-1:FRAC_BITS] : '0;
        inside_reg    <= inside_s3_reg;
    end

    assign done         = done_reg;
    assign interp_value = value_reg;
    assign inside_res   = inside_reg;

endmodule

// ----- rtl/core/bilinear_pixel_sampler.sv -----
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler
// Pixel store with bilinear sampling at fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken at every rising edge with start
//   high and busy low. busy stays low, so one transaction enters each cycle.
//   cmd = write stores write_value at (write_col, write_row) and gives no
//   result. cmd = sample reads the four neighbors of (sample_x, sample_y)
//   and gives one result.
//   Result channel: done is high for one cycle with interp_value and
//   inside_res; the receiver takes it in that cycle and cannot hold it off.
//   Path: bank reads and control are registered, then column blend, row
//   blend and output registers. Throughput: one transaction per cycle;
//   four parity banks give all four neighbors together, and a write uses
//   one bank port in its cycle, so a sample right after it sees the pixel.
//   Configuration: cfg_write with cfg_index and cfg_data sets image_width
//   or image_height; write it only while no sample is in flight.
//   Reset: both sizes return to 256 and the pipeline empties. The pixel
//   store is not cleared; pixels must be written before they are sampled.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler
    import bps_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [SIZE_BITS-1:0]          cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [COL_BITS-1:0]           write_col,
    input  logic [ROW_BITS-1:0]           write_row,
    input  logic [PIXEL_BITS-1:0]         write_value,
    input  logic signed [COORD_BITS-1:0]  sample_x,
    input  logic signed [COORD_BITS-1:0]  sample_y,
    output logic                          done,
    output logic [OUT_BITS-1:0]           interp_value,
    output logic                          inside_res
);

    logic                                     accept;
    logic [NUM_BANKS-1:0]                     bank_we;
    logic [NUM_BANKS-1:0][BANK_ADDR_BITS-1:0] bank_addr;
    logic [PIXEL_BITS-1:0]                    bank_wdata;
    logic [NUM_BANKS-1:0][PIXEL_BITS-1:0]     bank_rdata;
    sample_ctl_t                              ctl;

    // The pipeline never stalls: take every transaction offered.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the transaction and drive the bank ports.
    bps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .cmd         (cmd),
        .write_col   (write_col),
        .write_row   (write_row),
        .write_value (write_value),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .bank_we     (bank_we),
        .bank_addr   (bank_addr),
        .bank_wdata  (bank_wdata),
        .ctl         (ctl)
    );

    // Bank index is {row parity, column parity}.
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        bps_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .addr  (bank_addr[b]),
            .wdata (bank_wdata),
            .rdata (bank_rdata[b])
        );
    end

    // Weight the neighbors and present the result.
    bps_interp u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .bank_rdata   (bank_rdata),
        .done         (done),
        .interp_value (interp_value),
        .inside_res   (inside_res)
    );

endmodule

// ----- dv/tb_bilinear_pixel_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_bilinear_pixel_sampler
// Self-checking bench for the bilinear pixel sampler. Loads pixels, samples
// fixed-point coordinates under several image sizes, predicts every sample
// result in-bench and compares each strobed result in arrival order.
// ----------------------------------------------------------------------------
module tb_bilinear_pixel_sampler;
    import bps_pkg::*;

    localparam int COORD_ONE      = 1 << FRAC_BITS;
    localparam int COORD_HALF     = COORD_ONE / 2;
    localparam int STORE_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 50;

    // How a sample coordinate resolves against the current image size.
    typedef enum logic [1:0] {
        SK_OUTSIDE,
        SK_RAW,
        SK_BLEND
    } sample_kind_t;

    typedef struct {
        logic [OUT_BITS-1:0]          value;
        logic                         in_image;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } sample_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic                         cfg_index = CFG_IMAGE_WIDTH;
    logic [SIZE_BITS-1:0]         cfg_data = '0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         cmd = CMD_WRITE;
    logic [COL_BITS-1:0]          write_col = '0;
    logic [ROW_BITS-1:0]          write_row = '0;
    logic [PIXEL_BITS-1:0]        write_value = '0;
    logic signed [COORD_BITS-1:0] sample_x = '0;
    logic signed [COORD_BITS-1:0] sample_y = '0;
    logic                         done;
    logic [OUT_BITS-1:0]          interp_value;
    logic                         inside_res;

    // Bench copy of the block state: pixel store, which entries hold data,
    // and the two size registers after clamping.
    logic [PIXEL_BITS-1:0] pixel_mem [STORE_DEPTH];
    bit                    pixel_written [STORE_DEPTH];
    int                    img_width = MAX_WIDTH;
    int                    img_height = MAX_HEIGHT;

    sample_result_t pending_results[$];

    bit no_gaps = 1'b0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int n_samples = 0;
    int n_blend = 0;
    int n_raw = 0;
    int n_outside = 0;
    int n_writes = 0;
    int n_size_settings = 0;

    always #2 clk = ~clk;

    bilinear_pixel_sampler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .write_col    (write_col),
        .write_row    (write_row),
        .write_value  (write_value),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .done         (done),
        .interp_value (interp_value),
        .inside_res   (inside_res)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic signed [COORD_BITS-1:0] coord(input int v);
        return COORD_BITS'(v);
    endfunction

    // Zero acts as one, anything above the store size saturates.
    function automatic int clamp_size(input logic [SIZE_BITS-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic int pixel_at(input int col, input int row);
        return int'(pixel_mem[row * MAX_WIDTH + col]);
    endfunction

    // Resolve a coordinate into its integer cell and fraction, and decide
    // whether it falls outside, on the last column/row, or needs a blend.
    function automatic sample_kind_t classify_sample(
        input  logic signed [COORD_BITS-1:0] sx,
        input  logic signed [COORD_BITS-1:0] sy,
        output int                           xi,
        output int                           yi,
        output int                           dx,
        output int                           dy
    );
        int x;
        int y;
        x  = sx;
        y  = sy;
        xi = 0;
        yi = 0;
        dx = 0;
        dy = 0;
        // Far outside: below -0.5 or past the image edge.
        if (x < -COORD_HALF || y < -COORD_HALF ||
            x > img_width * COORD_ONE || y > img_height * COORD_ONE)
            return SK_OUTSIDE;
        // Slightly negative coordinates clamp to zero.
        if (x < 0)
            x = 0;
        if (y < 0)
            y = 0;
        xi = x >> FRAC_BITS;
        yi = y >> FRAC_BITS;
        dx = x & (COORD_ONE - 1);
        dy = y & (COORD_ONE - 1);
        // Coordinate exactly on the size lands in a cell that does not exist.
        if (xi >= img_width || yi >= img_height)
            return SK_OUTSIDE;
        if (xi + 1 == img_width || yi + 1 == img_height)
            return SK_RAW;
        return SK_BLEND;
    endfunction

    function automatic sample_result_t predict_sample(
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy
    );
        sample_result_t r;
        sample_kind_t   kind;
        int             xi;
        int             yi;
        int             dx;
        int             dy;
        int             acc;
        kind       = classify_sample(sx, sy, xi, yi, dx, dy);
        r.value    = '0;
        r.in_image = 1'b0;
        r.x        = sx;
        r.y        = sy;
        if (kind == SK_RAW)
        begin
            r.in_image = 1'b1;
            r.value    = OUT_BITS'(pixel_at(xi, yi) << FRAC_BITS);
        end
        else if (kind == SK_BLEND)
        begin
            // Weight the column pairs first, then blend across x; keep
            // FRAC_BITS fractional bits and truncate the rest.
            acc = (COORD_ONE - dx) * ((COORD_ONE - dy) * pixel_at(xi, yi)
                                      + dy * pixel_at(xi, yi + 1))
                + dx * ((COORD_ONE - dy) * pixel_at(xi + 1, yi)
                        + dy * pixel_at(xi + 1, yi + 1));
            r.in_image = 1'b1;
            r.value    = OUT_BITS'(acc >> FRAC_BITS);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Bias coordinates toward the image and its edges, with some noise
    // across the whole 18-bit range.
    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int size);
        int span;
        int pick;
        span = size * COORD_ONE;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return coord(int'($urandom_range(0, span + COORD_ONE)) - COORD_HALF);
        if (pick < 70)
            return coord(int'($urandom_range(0, size)) * COORD_ONE);
        if (pick < 85)
        begin
            case ($urandom_range(0, 5))
                0: return coord(-COORD_HALF);
                1: return coord(-COORD_HALF - 1);
                2: return coord(span);
                3: return coord(span + 1);
                4: return coord(span - 1 - int'($urandom_range(0, COORD_ONE - 1)));
                default: return coord(-int'($urandom_range(1, COORD_HALF)));
            endcase
        end
        return COORD_BITS'($urandom);
    endfunction

    // Drive one transaction and hold it until the block takes it, then
    // advance the bench state. start stays high into the next item unless
    // a gap is picked.
    task automatic send_item(
        input logic                         op,
        input logic [COL_BITS-1:0]          col,
        input logic [ROW_BITS-1:0]          row,
        input logic [PIXEL_BITS-1:0]        val,
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy
    );
        int gap;
        int idx;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= op;
        write_col   <= col;
        write_row   <= row;
        write_value <= val;
        sample_x    <= sx;
        sample_y    <= sy;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (op == CMD_WRITE)
        begin
            idx                = int'(row) * MAX_WIDTH + int'(col);
            pixel_mem[idx]     = val;
            pixel_written[idx] = 1'b1;
            n_writes++;
        end
        else
        begin
            pending_results.push_back(predict_sample(sx, sy));
            n_samples++;
        end
    endtask

    task automatic send_write(
        input logic [COL_BITS-1:0]   col,
        input logic [ROW_BITS-1:0]   row,
        input logic [PIXEL_BITS-1:0] val
    );
        send_item(CMD_WRITE, col, row, val, COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    // Load a random value into a pixel the sample is about to read, so no
    // unwritten entry is ever read.
    task automatic fill_pixel(input int col, input int row);
        if (!pixel_written[row * MAX_WIDTH + col])
            send_write(COL_BITS'(col), ROW_BITS'(row), PIXEL_BITS'($urandom));
    endtask

    task automatic send_sample(
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy
    );
        sample_kind_t kind;
        int           xi;
        int           yi;
        int           dx;
        int           dy;
        kind = classify_sample(sx, sy, xi, yi, dx, dy);
        if (kind != SK_OUTSIDE)
            fill_pixel(xi, yi);
        if (kind == SK_BLEND)
        begin
            fill_pixel(xi + 1, yi);
            fill_pixel(xi, yi + 1);
            fill_pixel(xi + 1, yi + 1);
        end
        send_item(CMD_SAMPLE, COL_BITS'($urandom), ROW_BITS'($urandom),
                  PIXEL_BITS'($urandom), sx, sy);
        case (kind)
            SK_BLEND: n_blend++;
            SK_RAW:   n_raw++;
            default:  n_outside++;
        endcase
    endtask

    // Drop start, wait for every outstanding result, then let the pipeline
    // run dry so trailing writes finish too.
    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [SIZE_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            img_width = clamp_size(data, MAX_WIDTH);
        else
            img_height = clamp_size(data, MAX_HEIGHT);
        @(posedge clk);
    endtask

    // Only call with the block idle.
    task automatic set_sizes(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
        write_config(CFG_IMAGE_WIDTH, w);
        write_config(CFG_IMAGE_HEIGHT, h);
        n_size_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset size 256x256: extreme pixel values and positions, clamping just
    // below zero, far outside on every side, the cell-beyond-size case, the
    // last column and row, and the coordinate range limits.
    task automatic test_default_size();
        send_write(8'd0, 8'd0, 8'h00);
        send_write(8'd1, 8'd0, 8'hFF);
        send_write(8'd0, 8'd1, 8'h5A);
        send_write(8'd1, 8'd1, 8'hA5);
        send_write(8'd255, 8'd255, 8'hFF);
        send_sample(coord(0), coord(0));
        send_sample(coord(-COORD_HALF), coord(-COORD_HALF));
        send_sample(coord(-COORD_HALF - 1), coord(0));
        send_sample(coord(0), coord(-COORD_HALF - 1));
        send_sample(coord(128), coord(77));
        send_sample(coord(255 * COORD_ONE + 200), coord(3 * COORD_ONE));
        send_sample(coord(5 * COORD_ONE), coord(255 * COORD_ONE + 1));
        send_sample(coord(256 * COORD_ONE), coord(0));
        send_sample(coord(0), coord(256 * COORD_ONE));
        send_sample(coord(256 * COORD_ONE + 1), coord(0));
        send_sample(coord(254 * COORD_ONE + 255), coord(254 * COORD_ONE + 1));
        send_sample(coord(131071), coord(131071));
        send_sample(coord(-131072), coord(-131072));
        settle();
    endtask

    // Size registers: zero acting as one, saturation above the maximum,
    // single-row and single-column images, and the smallest blending image.
    task automatic test_size_registers();
        set_sizes(9'd0, 9'd511);
        send_sample(coord(COORD_HALF), coord(10 * COORD_ONE + 5));
        send_sample(coord(COORD_ONE), coord(0));
        send_sample(coord(-1), coord(255 * COORD_ONE + 9));
        settle();
        set_sizes(9'd257, 9'd1);
        send_sample(coord(100 * COORD_ONE + 3), coord(COORD_HALF));
        send_sample(coord(50), coord(COORD_ONE));
        settle();
        set_sizes(9'd2, 9'd2);
        send_sample(coord(COORD_HALF), coord(COORD_HALF));
        send_sample(coord(COORD_ONE + COORD_HALF), coord(0));
        send_sample(coord(2 * COORD_ONE), coord(2 * COORD_ONE));
        send_sample(coord(2 * COORD_ONE + 1), coord(0));
        settle();
    endtask

    // Back-to-back bursts, with the sender held until all results are in.
    task automatic test_pause_until_drained();
        set_sizes(9'd16, 9'd16);
        no_gaps = 1'b1;
        repeat (2)
        begin
            repeat (16) send_sample(rand_coord(img_width), rand_coord(img_height));
            settle();
        end
        no_gaps = 1'b0;
    endtask

    // Random mix of writes and samples across several image sizes.
    task automatic test_random_traffic();
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
        int                   r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       begin w = 9'd256; h = 9'd256; end
                1:       begin w = 9'd1;   h = SIZE_BITS'($urandom_range(1, 256)); end
                2:       begin w = SIZE_BITS'($urandom_range(2, 8));
                               h = SIZE_BITS'($urandom_range(2, 8)); end
                3:       begin w = 9'd256; h = 9'd1; end
                default: begin w = SIZE_BITS'($urandom_range(0, 511));
                               h = SIZE_BITS'($urandom_range(0, 511)); end
            endcase
            set_sizes(w, h);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Toggle stretches of back-to-back traffic.
                if ($urandom_range(0, 24) == 0)
                    no_gaps = !no_gaps;
                if ($urandom_range(0, 99) == 0)
                    settle();
                r = $urandom_range(0, 99);
                if (r < 12)
                    send_write(COL_BITS'($urandom_range(0, img_width - 1)),
                               ROW_BITS'($urandom_range(0, img_height - 1)),
                               PIXEL_BITS'($urandom));
                else if (r < 22)
                    send_write(COL_BITS'($urandom), ROW_BITS'($urandom),
                               PIXEL_BITS'($urandom));
                else
                    send_sample(rand_coord(img_width), rand_coord(img_height));
            end
            no_gaps = 1'b0;
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking: each strobe takes the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        sample_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing expected: expected none, actual %0d/%0b",
                         $time, interp_value, inside_res);
            end
            else
            begin
                want = pending_results.pop_front();
                if (interp_value !== want.value)
                begin
                    mismatch_count++;
                    $display("%0t: interp_value at (%0d, %0d): expected %0d, actual %0d",
                             $time, want.x, want.y, want.value, interp_value);
                end
                if (inside_res !== want.in_image)
                begin
                    mismatch_count++;
                    $display("%0t: inside_res at (%0d, %0d): expected %0b, actual %0b",
                             $time, want.x, want.y, want.in_image, inside_res);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction and no result.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_size_registers();
        test_pause_until_drained();
        test_random_traffic();
        settle();

        $display("Covered %0d samples (%0d blended, %0d last column/row, %0d outside)",
                 n_samples, n_blend, n_raw, n_outside);
        $display("and %0d pixel writes over %0d image size settings.",
                 n_writes, n_size_settings);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
